>>> rtl/rau_pkg.sv
// rau_pkg: opcodes, sequencer states and shared constants for the rational unit.
// No dependencies.
`timescale 1ns / 1ps
package rau_pkg;
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_COMB,
    S_LOAD,
    S_GCD,
    S_GCDW,
    S_DIVN,
    S_DIVNW,
    S_DIVD,
    S_DIVDW,
    S_DONE
  } state_t;

  localparam int WIDE = 64;
  localparam logic [1:0] ORD_LT = 2'b11;
  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;
endpackage

>>> rtl/rau_if.sv
// rau_in_if / rau_out_if: valid-ready channels of the rational unit.
// Depends on nothing.
`timescale 1ns / 1ps
interface rau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] a_num;
  logic [30:0]        a_den;
  logic signed [31:0] b_num;
  logic [30:0]        b_den;
  modport source(output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink(input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] res_num;
  logic [62:0]        res_den;
  logic signed [1:0]  order;
  logic               div_zero;
  modport source(output valid, res_num, res_den, order, div_zero, input ready);
  modport sink(input valid, res_num, res_den, order, div_zero, output ready);
endinterface

>>> rtl/rau_divider.sv
// rau_divider: 64-bit restoring divider, one quotient bit per cycle.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_divider
  import rau_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [WIDE-1:0] dividend,
  input  logic [WIDE-1:0] divisor,
  output logic            done,
  output logic [WIDE-1:0] quotient,
  output logic [WIDE-1:0] remainder
);
  logic [WIDE-1:0] rem, quo, dsr;
  logic [6:0]      cnt;
  logic            busy;
  logic [WIDE:0]   trial;
  logic [WIDE:0]   diff;

  assign trial = {rem, quo[WIDE-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        if (!diff[WIDE]) begin
          rem <= diff[WIDE-1:0];
          quo <= {quo[WIDE-2:0], 1'b1};
        end else begin
          rem <= trial[WIDE-1:0];
          quo <= {quo[WIDE-2:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'(WIDE - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
endmodule

>>> rtl/rational_arith_unit_core.sv
// Rational arithmetic unit: cross-multiply, Euclidean gcd, exact reduction.
// The number of Euclid steps is zero when the raw numerator or denominator is zero.
// One shared 32x32 multiplier and one shared 64-bit divider.
// A new item is accepted only after the previous result is taken; ready is high only when idle.
// Synchronous active-high reset returns the sequencer to idle, no output valid.
`timescale 1ns / 1ps
module rational_arith_unit_core
  import rau_pkg::*;
#(
  parameter int OPERAND_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  localparam int NB = OPERAND_BITS;

  state_t state, state_next;
  logic [2:0] op;
  logic signed [31:0] an, ad, bn, bd;
  logic signed [63:0] p0, p1, p2, n_raw, d_raw;
  logic [63:0] gx, gy, nm, dm;
  logic neg, dz;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic dv_start, dv_done;
  logic [63:0] dv_n, dv_d, dv_q, dv_r;
  logic [63:0] n_mag, d_mag, rn;
  logic zero_case;

  logic signed [NB-1:0] an_s, bn_s;
  logic [NB-2:0] ad_u, bd_u;
  assign an_s = in_ch.a_num[NB-1:0];
  assign bn_s = in_ch.b_num[NB-1:0];
  assign ad_u = in_ch.a_den[NB-2:0];
  assign bd_u = in_ch.b_den[NB-2:0];

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_DONE);

  // single shared multiplier, operands chosen by step
  always_comb begin
    mul_a = an;
    mul_b = bd;
    unique case (state)
      S_MUL1: mul_b = (op == OP_MUL) ? bn : bd;
      S_MUL2: begin mul_a = ad; mul_b = (op == OP_DIV) ? bn : bd; end
      S_MUL3: begin mul_a = ad; mul_b = bn; end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  rau_divider u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_n), .divisor(dv_d),
    .done(dv_done), .quotient(dv_q), .remainder(dv_r)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_ch.valid) state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_MUL3;
      S_MUL3:  state_next = S_COMB;
      S_COMB:  state_next = S_LOAD;
      S_LOAD:  state_next = S_GCD;
      S_GCD:   state_next = (gy == 64'd0) ? S_DIVN : S_GCDW;
      S_GCDW:  if (dv_done) state_next = S_GCD;
      S_DIVN:  state_next = S_DIVNW;
      S_DIVNW: if (dv_done) state_next = S_DIVD;
      S_DIVD:  state_next = S_DIVDW;
      S_DIVDW: if (dv_done) state_next = S_DONE;
      S_DONE:  if (out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // divider is started for one cycle; its operands are captured at start
  always_comb begin
    dv_start = 1'b0;
    dv_n = gx;
    dv_d = gy;
    unique case (state)
      S_GCD:  dv_start = (gy != 64'd0);
      S_DIVN: begin dv_start = 1'b1; dv_n = nm; dv_d = gx; end
      S_DIVD: begin dv_start = 1'b1; dv_n = dm; dv_d = gx; end
      default: ;
    endcase
  end

  assign n_mag = n_raw[63] ? 64'(-n_raw) : 64'(n_raw);
  assign d_mag = d_raw[63] ? 64'(-d_raw) : 64'(d_raw);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          op <= in_ch.opcode;
          an <= 32'(an_s);
          bn <= 32'(bn_s);
          ad <= {{(33-NB){1'b0}}, ad_u};
          bd <= {{(33-NB){1'b0}}, bd_u};
        end
        S_MUL1: p0 <= mul_p;
        S_MUL2: p1 <= mul_p;
        S_MUL3: p2 <= mul_p;
        S_COMB: begin
          dz <= (op == OP_DIV) && (bn == 32'sd0);
          // divide by a zero fraction leaves d_raw at zero, which reduces to 0/1
          case (op) inside
            OP_ADD:         begin n_raw <= p0 + p2; d_raw <= p1; end
            OP_SUB, OP_CMP: begin n_raw <= p0 - p2; d_raw <= p1; end
            OP_MUL, OP_DIV: begin n_raw <= p0; d_raw <= p1; end
            default:        begin n_raw <= 64'sd0; d_raw <= 64'sd1; end
          endcase
        end
        S_LOAD: begin
          neg <= n_raw[63] ^ d_raw[63];
          if (n_raw == 64'sd0 || d_raw == 64'sd0) begin
            nm <= 64'd0;
            dm <= 64'd1;
            gx <= 64'd1;
            gy <= 64'd0;
          end else begin
            nm <= n_mag;
            dm <= d_mag;
            gx <= n_mag;
            gy <= d_mag;
          end
        end
        S_GCDW: if (dv_done) begin
          gx <= gy;
          gy <= dv_r;
        end
        S_DIVNW: if (dv_done) nm <= dv_q;
        S_DIVDW: if (dv_done) dm <= dv_q;
        default: ;
      endcase
    end
  end

  assign zero_case = (nm == 64'd0);
  assign rn = neg ? 64'(-nm) : nm;
  assign out_ch.res_num  = rn;
  assign out_ch.res_den  = dm[62:0];
  assign out_ch.div_zero = dz;
  always_comb begin
    out_ch.order = ORD_EQ;
    if (op == OP_CMP && !zero_case) out_ch.order = rn[63] ? ORD_LT : ORD_GT;
  end

  a_done_den: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.res_den != 63'd0)
    else $error("zero denominator on output");
  a_busy_nready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready)
    else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.res_num))
    else $error("result dropped");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.div_zero) |-> out_ch.res_num == 64'sd0)
    else $error("div by zero gave nonzero");
endmodule

>>> tb/sv/rational_arith_unit_core_tb.sv
// Testbench for rational_arith_unit_core: directed and random fraction operations,
// checked against an in-bench reducing predictor. Depends on rau_pkg and rau_if.
`timescale 1ns / 1ps
module rational_arith_unit_core_tb;
  import rau_pkg::*;

  localparam int  N_RANDOM  = 1430;
  localparam int  CALM_FROM = 1250;   // no idling past this many random items
  localparam longint LIMIT  = 64'd40_000_000;

  typedef struct packed {
    logic signed [63:0] num;
    logic [62:0]        den;
    logic signed [1:0]  ord;
    logic               dz;
  } frac_res_t;

  class frac_scoreboard;
    frac_res_t pending[$];
    int errors;
    int checked;

    task report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("MISMATCH @%0t %s: got %0h expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    function frac_res_t reduce_fraction(input logic [2:0] op, input logic signed [31:0] an,
                                        input logic [30:0] ad, input logic signed [31:0] bn,
                                        input logic [30:0] bd);
      longint n, d, adl, bdl, anl, bnl;
      longint unsigned nm, dm, x, y, t;
      bit neg;
      frac_res_t r;
      anl = an; bnl = bn;
      adl = longint'({33'b0, ad});
      bdl = longint'({33'b0, bd});
      n = 0; d = 1;
      r.dz = 1'b0;
      r.ord = ORD_EQ;
      case (op) inside
        OP_ADD: begin n = anl * bdl + adl * bnl; d = adl * bdl; end
        OP_SUB, OP_CMP: begin n = anl * bdl - adl * bnl; d = adl * bdl; end
        OP_MUL: begin n = anl * bnl; d = adl * bdl; end
        OP_DIV: begin
          if (bnl == 0) r.dz = 1'b1;
          else begin n = anl * bdl; d = adl * bnl; end
        end
        default: ;
      endcase
      nm = (n < 0) ? -n : n;
      dm = (d < 0) ? -d : d;
      neg = (n < 0) != (d < 0);
      if (nm == 0 || dm == 0) begin
        r.num = 0; r.den = 1;
      end else begin
        x = nm; y = dm;
        while (y != 0) begin t = x % y; x = y; y = t; end
        nm = nm / x; dm = dm / x;
        r.num = neg ? -nm : nm;
        r.den = dm[62:0];
      end
      if (op == OP_CMP)
        r.ord = (r.num == 0) ? ORD_EQ : r.num[63] ? ORD_LT : ORD_GT;
      return r;
    endfunction

    function void note_operands(input logic [2:0] op, input logic signed [31:0] an,
                                input logic [30:0] ad, input logic signed [31:0] bn,
                                input logic [30:0] bd);
      pending.push_back(reduce_fraction(op, an, ad, bn, bd));
    endfunction

    task check_result(input frac_res_t got);
      frac_res_t want;
      if (pending.size() == 0) begin
        $display("MISMATCH @%0t unexpected result transaction", $realtime);
        errors++;
      end else begin
        want = pending.pop_front();
        checked++;
        if (got.num !== want.num) report("res_num", got.num, want.num);
        if (got.den !== want.den) report("res_den", {1'b0, got.den}, {1'b0, want.den});
        if (got.ord !== want.ord) report("order", {62'b0, got.ord}, {62'b0, want.ord});
        if (got.dz !== want.dz) report("div_zero", {63'b0, got.dz}, {63'b0, want.dz});
      end
    endtask
  endclass

  logic clk;
  logic rst;
  rau_in_if  in_ch();
  rau_out_if out_ch();
  frac_scoreboard sb;
  longint cycles;
  bit calm;
  bit hold_off;
  int sent;
  int op_seen[8];

  rational_arith_unit_core dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // monitor: results sampled before this edge's updates
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.res_num, out_ch.res_den, out_ch.order, out_ch.div_zero});
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        for (n = 0; n < 4000; n++) @(posedge clk);
        hold_off = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_fractions(input logic [2:0] op, input logic signed [31:0] an,
                                input logic [30:0] ad, input logic signed [31:0] bn,
                                input logic [30:0] bd);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.a_num  <= an;
    in_ch.a_den  <= ad;
    in_ch.b_num  <= bn;
    in_ch.b_den  <= bd;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_operands(op, an, ad, bn, bd);
    op_seen[op]++;
    sent++;
  endtask

  function automatic logic [31:0] pick_num();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 40) - 20;
      2: return 32'(($urandom_range(0, 3000) - 1500) * $urandom_range(1, 720));
      3: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    case ($urandom_range(0, 4))
      0: return 31'($urandom);
      1: return 31'($urandom_range(1, 30));
      2: return 31'($urandom_range(1, 5000) * $urandom_range(1, 360));
      3: return ($urandom_range(0, 9) == 0) ? 31'd0 : 31'h7fff_ffff;
      default: return 31'($urandom >> $urandom_range(1, 31));
    endcase
  endfunction

  initial begin
    int i;
    logic [2:0] op;
    sb = new();
    calm = 1'b0;
    hold_off = 1'b0;
    sent = 0;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_ADD;
    in_ch.a_num <= '0;
    in_ch.a_den <= 31'd1;
    in_ch.b_num <= '0;
    in_ch.b_den <= 31'd1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every opcode, zero cases
    for (i = 0; i < 8; i++)
      send_fractions(3'(i), 32'sd6, 31'd4, -32'sd9, 31'd6);
    send_fractions(OP_ADD, 32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
    send_fractions(OP_SUB, 32'h8000_0000, 31'd1, 32'h7fff_ffff, 31'h7fff_ffff);
    send_fractions(OP_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
    send_fractions(OP_MUL, 32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 31'd1);
    send_fractions(OP_DIV, 32'sd5, 31'd3, 32'sd0, 31'd7);
    send_fractions(OP_DIV, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'h7fff_ffff);
    send_fractions(OP_DIV, 32'sd7, 31'd2, -32'sd14, 31'd4);
    send_fractions(OP_CMP, 32'sd1, 31'd2, 32'sd2, 31'd4);
    send_fractions(OP_CMP, -32'sd1, 31'd3, 32'sd1, 31'd3);
    send_fractions(OP_CMP, 32'sd1, 31'd3, -32'sd1, 31'd3);
    send_fractions(OP_MUL, 32'sd0, 31'd9, 32'sd5, 31'd7);
    send_fractions(OP_ADD, 32'sd3, 31'd0, 32'sd4, 31'd5);
    send_fractions(OP_CMP, 32'sd3, 31'd0, 32'sd4, 31'd0);
    send_fractions(OP_DIV, 32'sd3, 31'd0, 32'sd4, 31'd5);

    for (i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_off = 1'b1;
      if (i == CALM_FROM) calm = 1'b1;
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      send_fractions(op, pick_num(), pick_den(), pick_num(), pick_den());
    end
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8000) @(posedge clk);

    $display("Sent %0d fraction transactions, %0d results checked", sent, sb.checked);
    $display("Ops add/sub/mul/div/cmp/unused: %0d/%0d/%0d/%0d/%0d/%0d", op_seen[0],
             op_seen[1], op_seen[2], op_seen[3], op_seen[4],
             op_seen[5] + op_seen[6] + op_seen[7]);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
